### rtl/sturm_sign_variation_count_core_assert.svh
// Assertion macros used by the sign-variation counter controller.
`ifndef STURM_SIGN_VARIATION_COUNT_CORE_ASSERT_SVH
`define STURM_SIGN_VARIATION_COUNT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SSVC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");
// next-cycle implication
`define SSVC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define SSVC_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SSVC_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

### rtl/ssvc_pkg.sv
// Shared types and constants of the sign-variation counter.
`timescale 1ns / 1ps
`default_nettype none
package ssvc_pkg;

    localparam int MAX_POLYS_DEF  = 16;
    localparam int MAX_COEFFS_DEF = 16;

    localparam int COEFF_W  = 32;
    localparam int ACC_W    = 48;
    localparam int ACTIVE_W = 5;
    localparam int COUNT_W  = 4;
    localparam int PIDX_W   = 4;
    localparam int CIDX_W   = 4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic mem_we;      // write coefficient store
        logic wr_zero;     // write data is zero (clearing sweep)
        logic mem_re;      // read coefficient store into read register
        logic x_load;      // capture x, clear count/sign/root
        logic acc_load;    // acc <= top coefficient
        logic mul_en;      // register partial products
        logic acc_step;    // acc <= sat(products + coefficient)
        logic sign_upd;    // fold acc sign into count
        logic first_poly;  // current polynomial is the first one
        logic out_load;    // move result into output register
    } t_ssvc_cmd;

endpackage
`default_nettype wire

### rtl/ssvc_dp.sv
// Datapath: coefficient store, Horner multiply-add, sign-change counter.
`timescale 1ns / 1ps
`default_nettype none
module ssvc_dp
    import ssvc_pkg::*;
#(
    parameter int MAX_POLYS  = MAX_POLYS_DEF,
    parameter int MAX_COEFFS = MAX_COEFFS_DEF,
    parameter int DEPTH      = MAX_POLYS * MAX_COEFFS,
    parameter int AW         = $clog2(DEPTH)
) (
    input  wire                       i_clk,
    input  wire t_ssvc_cmd            i_cmd,
    input  wire        [AW-1:0]       i_addr,
    input  wire signed [COEFF_W-1:0]  i_coeff_value,
    input  wire signed [COEFF_W-1:0]  i_x_value,
    output logic       [COUNT_W-1:0]  o_sign_changes,
    output logic                      o_on_root
);

    localparam int SUM_W = 66;
    localparam logic signed [SUM_W-1:0] AccMax = (SUM_W'(1) <<< (ACC_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] AccMin = -(SUM_W'(1) <<< (ACC_W - 1));
    localparam logic [COUNT_W-1:0] CountMax = '1;

    logic        [COEFF_W-1:0] r_mem [DEPTH];
    logic signed [COEFF_W-1:0] r_rdata;
    logic signed [COEFF_W-1:0] r_x;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [63:0]        r_hi;
    logic signed [ACC_W:0]     r_lo;
    logic        [COUNT_W-1:0] r_count;
    logic                      r_has_sign;
    logic                      r_last_neg;
    logic                      r_root;
    logic        [COUNT_W-1:0] r_out_changes;
    logic                      r_out_root;

    logic signed [15:0]        w_xh;
    logic signed [16:0]        w_xl;
    logic signed [63:0]        w_hi;
    logic signed [64:0]        w_lo;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [ACC_W-1:0]   w_sat;
    logic                      w_pos;
    logic                      w_neg;

    // x = xh * 2^16 + xl, xh signed, xl unsigned
    assign w_xh = r_x[31:16];
    assign w_xl = {1'b0, r_x[15:0]};
    assign w_hi = r_acc * w_xh;
    assign w_lo = r_acc * w_xl;

    assign w_sum = SUM_W'(r_hi) + SUM_W'(r_lo) + SUM_W'(r_rdata);

    always_comb begin
        if (w_sum > AccMax) begin
            w_sat = AccMax[ACC_W-1:0];
        end else if (w_sum < AccMin) begin
            w_sat = AccMin[ACC_W-1:0];
        end else begin
            w_sat = w_sum[ACC_W-1:0];
        end
    end

    assign w_neg = r_acc[ACC_W-1];
    assign w_pos = !r_acc[ACC_W-1] && (r_acc != '0);

    // coefficient store, one port, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[i_addr] <= i_cmd.wr_zero ? '0 : i_coeff_value;
        end
        if (i_cmd.mem_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.x_load) begin
            r_x <= i_x_value;
        end
        if (i_cmd.acc_load) begin
            r_acc <= ACC_W'(r_rdata);
        end else if (i_cmd.acc_step) begin
            r_acc <= w_sat;
        end
        if (i_cmd.mul_en) begin
            r_hi <= w_hi;
            r_lo <= w_lo[64:16];   // floor(acc * xl / 2^16)
        end
    end

    // strict sign changes, zeros skipped
    always_ff @(posedge i_clk) begin
        if (i_cmd.x_load) begin
            r_count    <= '0;
            r_has_sign <= 1'b0;
            r_last_neg <= 1'b0;
            r_root     <= 1'b0;
        end else if (i_cmd.sign_upd) begin
            if (w_pos) begin
                if (r_has_sign && r_last_neg && (r_count != CountMax)) begin
                    r_count <= r_count + 1'b1;
                end
                r_has_sign <= 1'b1;
                r_last_neg <= 1'b0;
            end else if (w_neg) begin
                if (r_has_sign && !r_last_neg && (r_count != CountMax)) begin
                    r_count <= r_count + 1'b1;
                end
                r_has_sign <= 1'b1;
                r_last_neg <= 1'b1;
            end else if (i_cmd.first_poly) begin
                r_root <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_changes <= r_count;
            r_out_root    <= r_root;
        end
    end

    assign o_sign_changes = r_out_changes;
    assign o_on_root      = r_out_root;

endmodule
`default_nettype wire

### rtl/ssvc_ctrl.sv
// Controller: clearing sweep, item handshake, Horner sequencing, result register control.
`timescale 1ns / 1ps
`default_nettype none
`include "sturm_sign_variation_count_core_assert.svh"
module ssvc_ctrl
    import ssvc_pkg::*;
#(
    parameter int MAX_POLYS  = MAX_POLYS_DEF,
    parameter int MAX_COEFFS = MAX_COEFFS_DEF,
    parameter int DEPTH      = MAX_POLYS * MAX_COEFFS,
    parameter int AW         = $clog2(DEPTH)
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire                   i_operation,
    input  wire  [PIDX_W-1:0]     i_poly_index,
    input  wire  [CIDX_W-1:0]     i_coeff_index,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [ACTIVE_W-1:0]   i_cfg_data,
    output t_ssvc_cmd             o_cmd,
    output logic [AW-1:0]         o_addr
);

    localparam int PW = $clog2(MAX_POLYS);
    localparam int CW = $clog2(MAX_COEFFS);
    localparam logic [6:0]    MaxPolysV = 7'(MAX_POLYS);
    localparam logic [CW-1:0] TopCoeff  = CW'(MAX_COEFFS - 1);
    localparam logic [CW-1:0] NextCoeff = CW'(MAX_COEFFS - 2);
    localparam logic [AW-1:0] LastAddr  = AW'(DEPTH - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_INIT  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_SIGN  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [PW-1:0]       r_poly, n_poly;
    logic [CW-1:0]       r_coeff, n_coeff;
    logic [ACTIVE_W-1:0] r_active;
    logic                r_out_valid, n_out_valid;

    logic [PW-1:0]       w_last_poly;
    logic [PW-1:0]       w_rd_poly;
    logic [CW-1:0]       w_rd_coeff;
    logic [AW-1:0]       w_rd_addr;
    logic [AW-1:0]       w_wr_addr;
    logic                w_wr_ok;
    logic                w_accept;
    logic                w_out_free;
    logic                w_eval_go;
    logic                w_step_last;
    logic                w_busy;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_eval_go   = w_accept && (i_operation == OP_EVAL);
    assign w_step_last = (r_state == S_ADD) && (r_coeff == '0);
    assign w_busy      = r_state inside {S_INIT, S_MUL, S_ADD, S_SIGN};

    // active count clamped to 1..MAX_POLYS
    always_comb begin
        if (r_active == '0) begin
            w_last_poly = '0;
        end else if ({2'b00, r_active} > MaxPolysV) begin
            w_last_poly = PW'(MAX_POLYS - 1);
        end else begin
            w_last_poly = PW'(r_active - 1'b1);
        end
    end

    assign w_wr_ok   = (32'(i_poly_index) < 32'(MAX_POLYS)) &&
                       (32'(i_coeff_index) < 32'(MAX_COEFFS));
    assign w_wr_addr = AW'(32'(i_poly_index) * MAX_COEFFS + 32'(i_coeff_index));
    assign w_rd_addr = AW'(32'(w_rd_poly) * MAX_COEFFS + 32'(w_rd_coeff));

    // store address: sweep pointer, write target, else the read address
    always_comb begin
        if (r_state == S_CLEAR) begin
            o_addr = r_clr;
        end else if ((r_state == S_IDLE) && w_accept && (i_operation == OP_WRITE)) begin
            o_addr = w_wr_addr;
        end else begin
            o_addr = w_rd_addr;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_poly      = r_poly;
        n_coeff     = r_coeff;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        w_rd_poly   = r_poly;
        w_rd_coeff  = TopCoeff;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        o_cmd.first_poly = (r_poly == '0);

        case (r_state)
            S_CLEAR: begin
                o_cmd.mem_we  = 1'b1;
                o_cmd.wr_zero = 1'b1;
                if (r_clr == LastAddr) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                w_rd_poly  = '0;
                w_rd_coeff = TopCoeff;
                if (w_accept) begin
                    if (i_operation == OP_EVAL) begin
                        o_cmd.x_load = 1'b1;
                        o_cmd.mem_re = 1'b1;
                        n_poly       = '0;
                        n_state      = S_INIT;
                    end else begin
                        o_cmd.mem_we = w_wr_ok;
                    end
                end
            end
            S_INIT: begin
                o_cmd.acc_load = 1'b1;
                o_cmd.mem_re   = 1'b1;
                w_rd_coeff     = NextCoeff;
                n_coeff        = NextCoeff;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_ADD;
            end
            S_ADD: begin
                o_cmd.acc_step = 1'b1;
                if (r_coeff == '0) begin
                    n_state = S_SIGN;
                end else begin
                    o_cmd.mem_re = 1'b1;
                    w_rd_coeff   = r_coeff - 1'b1;
                    n_coeff      = r_coeff - 1'b1;
                    n_state      = S_MUL;
                end
            end
            S_SIGN: begin
                o_cmd.sign_upd = 1'b1;
                if (r_poly == w_last_poly) begin
                    n_state = S_DONE;
                end else begin
                    // fetch next top coefficient while folding this sign
                    o_cmd.mem_re = 1'b1;
                    w_rd_poly    = PW'(r_poly + 1'b1);
                    w_rd_coeff   = TopCoeff;
                    n_poly       = PW'(r_poly + 1'b1);
                    n_state      = S_INIT;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_poly      <= '0;
            r_coeff     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_poly      <= n_poly;
            r_coeff     <= n_coeff;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_active <= i_cfg_data;
        end
    end

    `SSVC_ASSERT_NXT(a_eval_starts, i_clk, i_rst_n, w_eval_go, r_state == S_INIT)
    `SSVC_ASSERT_NXT(a_poly_ends, i_clk, i_rst_n, w_step_last, r_state == S_SIGN)
    `SSVC_ASSERT_IMP(a_out_free, i_clk, i_rst_n, o_cmd.out_load, !r_out_valid || !i_out_stall)
    `SSVC_ASSERT_IMP(a_one_port, i_clk, i_rst_n, o_cmd.mem_re, !o_cmd.mem_we)
    `SSVC_ASSERT_IMP(a_poly_range, i_clk, i_rst_n, w_busy, r_poly <= w_last_poly)

endmodule
`default_nettype wire

### rtl/sturm_sign_variation_count_core.sv
// Top level of the Sturm sequence sign-variation counter.
//
// Usage:
// - Input channel (i_in_valid / o_in_stall): a transfer with i_operation = write
//   stores i_coeff_value at (i_poly_index, i_coeff_index); out-of-range writes
//   are dropped. A transfer with i_operation = evaluate starts a count at i_x_value.
// - Output channel (o_out_valid / i_out_stall): one transfer per evaluate item,
//   carrying o_sign_changes and o_on_root. Writes give no result.
// - Config channel (i_cfg_valid / o_cfg_ready, always ready): i_cfg_data sets the
//   number of active polynomials (0 acts as 1, above MAX_POLYS as MAX_POLYS).
// - Rate: a write is taken whenever the block is idle. An evaluation holds
//   o_in_stall high until its result is loaded; for each of N active polynomials
//   it loads the top coefficient, then every Horner step is a product step then a
//   saturating add step on the 48-bit accumulator, then the sign is folded in.
// - Result sits in an output register; while it is stalled the block still
//   takes and runs the next item, and only holds before its own result load.
// - Reset (synchronous, active low): the coefficient store is swept to zero,
//   one word per cycle over all MAX_POLYS * MAX_COEFFS words (256 by default),
//   with o_in_stall high; config writes are taken meanwhile. active_polys resets to 1.
`timescale 1ns / 1ps
`default_nettype none
module sturm_sign_variation_count_core
    import ssvc_pkg::*;
#(
    parameter int MAX_POLYS  = MAX_POLYS_DEF,
    parameter int MAX_COEFFS = MAX_COEFFS_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  wire                       i_operation,
    input  wire        [PIDX_W-1:0]   i_poly_index,
    input  wire        [CIDX_W-1:0]   i_coeff_index,
    input  wire signed [COEFF_W-1:0]  i_coeff_value,
    input  wire signed [COEFF_W-1:0]  i_x_value,
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output logic       [COUNT_W-1:0]  o_sign_changes,
    output logic                      o_on_root,
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire        [ACTIVE_W-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_POLYS * MAX_COEFFS;
    localparam int AW    = $clog2(DEPTH);

    t_ssvc_cmd     w_cmd;
    logic [AW-1:0] w_addr;

    ssvc_ctrl #(
        .MAX_POLYS  (MAX_POLYS),
        .MAX_COEFFS (MAX_COEFFS),
        .DEPTH      (DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_poly_index  (i_poly_index),
        .i_coeff_index (i_coeff_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_cmd         (w_cmd),
        .o_addr        (w_addr)
    );

    ssvc_dp #(
        .MAX_POLYS  (MAX_POLYS),
        .MAX_COEFFS (MAX_COEFFS),
        .DEPTH      (DEPTH),
        .AW         (AW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .i_addr         (w_addr),
        .i_coeff_value  (i_coeff_value),
        .i_x_value      (i_x_value),
        .o_sign_changes (o_sign_changes),
        .o_on_root      (o_on_root)
    );

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the Sturm sequence sign-variation counter.
`timescale 1ns / 1ps
module tb_top;
    import ssvc_pkg::*;

    localparam int MAX_POLYS   = MAX_POLYS_DEF;
    localparam int MAX_COEFFS  = MAX_COEFFS_DEF;
    localparam int ITEM_TARGET = 1550;
    localparam int B2B_ITEMS   = 300;      // stretch run with no idling on either side
    localparam int EVAL_CYCLES = 2 + MAX_POLYS * 2 * MAX_COEFFS;
    // Slowest legal run: every item a full 16-poly evaluation plus stalls, taken 4x over.
    localparam longint CYCLE_LIMIT = 4_000_000;

    // Q32.16 accumulator bounds of the 48-bit Horner register
    localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam logic [COEFF_W-1:0] Q_ONE = 32'h0001_0000;

    typedef struct packed {
        logic [COUNT_W-1:0] sign_changes;
        logic               on_root;
    } t_sturm_result;

    // ------------------------------------------------------------------
    // Signals; every block input has a known value from time zero
    // ------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                operation = OP_WRITE;
    logic [PIDX_W-1:0]   poly_index = '0;
    logic [CIDX_W-1:0]   coeff_index = '0;
    logic [COEFF_W-1:0]  coeff_value = '0;
    logic [COEFF_W-1:0]  x_value = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [COUNT_W-1:0]  sign_changes;
    logic                on_root;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [ACTIVE_W-1:0] cfg_data = '0;

    sturm_sign_variation_count_core u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_operation    (operation),
        .i_poly_index   (poly_index),
        .i_coeff_index  (coeff_index),
        .i_coeff_value  (coeff_value),
        .i_x_value      (x_value),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_sign_changes (sign_changes),
        .o_on_root      (on_root),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    // 12 ns period
    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------
    // Shadow state of the block: coefficient store and active count
    // ------------------------------------------------------------------
    logic signed [COEFF_W-1:0] coeff_model [MAX_POLYS][MAX_COEFFS];
    logic [ACTIVE_W-1:0]       active_model = 5'd1;
    t_sturm_result             pending_counts [$];   // results owed by the block, oldest first

    int     items_sent   = 0;
    int     mismatches   = 0;
    longint cycle_count  = 0;
    bit     tx_idle_on   = 1'b0;
    bit     rx_idle_on   = 1'b0;
    int     rx_hold_left = 0;      // receiver holds off while nonzero
    t_sturm_result want;

    initial begin
        for (int p = 0; p < MAX_POLYS; p++)
            for (int k = 0; k < MAX_COEFFS; k++)
                coeff_model[p][k] = '0;
    end

    // Horner's rule on one stored polynomial. x is split into a signed integer
    // part and an unsigned fraction so both partial products fit in 64 bits;
    // floor rounding of the fraction product matches an arithmetic shift.
    function automatic longint horner_q16(input int p, input logic signed [COEFF_W-1:0] x);
        longint x_hi, x_lo, acc;
        x_hi = longint'(x) >>> 16;
        x_lo = longint'(x) - x_hi * 65536;
        acc  = longint'(coeff_model[p][MAX_COEFFS-1]);
        for (int n = MAX_COEFFS - 2; n >= 0; n--) begin
            acc = acc * x_hi + ((acc * x_lo) >>> 16) + longint'(coeff_model[p][n]);
            if (acc > ACC_MAX)
                acc = ACC_MAX;
            else if (acc < ACC_MIN)
                acc = ACC_MIN;
        end
        return acc;
    endfunction

    // Strict sign changes along the active sequence; zero values carry no sign.
    function automatic t_sturm_result predict_sign_changes(input logic signed [COEFF_W-1:0] x);
        t_sturm_result r;
        int            npoly;
        int            prev_sign;
        longint        v;
        npoly = (active_model == 0) ? 1 :
                (active_model > MAX_POLYS) ? MAX_POLYS : int'(active_model);
        r.sign_changes = '0;
        r.on_root      = 1'b0;
        prev_sign      = 0;
        for (int i = 0; i < npoly; i++) begin
            v = horner_q16(i, x);
            if (v > 0) begin
                if (prev_sign < 0 && r.sign_changes != '1)
                    r.sign_changes = r.sign_changes + 1'b1;
                prev_sign = 1;
            end else if (v < 0) begin
                if (prev_sign > 0 && r.sign_changes != '1)
                    r.sign_changes = r.sign_changes + 1'b1;
                prev_sign = -1;
            end else if (i == 0) begin
                r.on_root = 1'b1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus value pickers
    // ------------------------------------------------------------------
    // Mostly modest Q16.16 magnitudes so Horner sums stay in range and the
    // signs mean something; some zeros, extremes and raw words for saturation.
    function automatic logic [COEFF_W-1:0] rand_coeff();
        logic [COEFF_W-1:0] mag;
        mag = $urandom_range(32'h0008_0000);
        case ($urandom_range(9))
            0:       return '0;
            1:       return $urandom;
            2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(1) ? -mag : mag;
        endcase
    endfunction

    function automatic logic [COEFF_W-1:0] rand_x();
        logic [COEFF_W-1:0] mag;
        int                 whole;
        mag   = $urandom_range(32'h0004_0000);
        whole = int'($urandom_range(8)) - 4;
        case ($urandom_range(9))
            0:       return '0;
            1, 2:    return $urandom;
            3, 4:    return whole <<< 16;
            default: return $urandom_range(1) ? -mag : mag;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input driver: one transfer per call. Payload changes at the falling
    // edge; valid is left high on return so back-to-back items never see
    // a low-high toggle in one time step.
    // ------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [PIDX_W-1:0] pidx,
                             input logic [CIDX_W-1:0] cidx,
                             input logic [COEFF_W-1:0] coeff,
                             input logic [COEFF_W-1:0] xval);
        @(negedge clk);
        while (tx_idle_on && $urandom_range(99) < 10) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        poly_index  <= pidx;
        coeff_index <= cidx;
        coeff_value <= coeff;
        x_value     <= xval;
        do
            @(posedge clk);
        while (in_stall);
        // transfer taken at this edge: advance the shadow state
        items_sent++;
        if (op == OP_WRITE) begin
            if (pidx < MAX_POLYS && cidx < MAX_COEFFS)
                coeff_model[pidx][cidx] = coeff;
        end else begin
            pending_counts = {pending_counts, predict_sign_changes(xval)};
        end
    endtask

    task automatic write_coeff(input int p, input int k, input logic [COEFF_W-1:0] v);
        send_item(OP_WRITE, p[PIDX_W-1:0], k[CIDX_W-1:0], v, $urandom);
    endtask

    // unused write fields ride along with random content
    task automatic eval_at(input logic [COEFF_W-1:0] x);
        send_item(OP_EVAL, PIDX_W'($urandom), CIDX_W'($urandom), $urandom, x);
    endtask

    // Sender pause: drop valid and wait for every owed result. A short settle
    // follows for a trailing write, which gives no result.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Called with no item in flight; the first call falls in the reset sweep.
    task automatic cfg_write(input logic [ACTIVE_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        active_model = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, or a long counted hold-off when requested
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rx_hold_left > 0) begin
            out_stall <= 1'b1;
            rx_hold_left = rx_hold_left - 1;
        end else if (rx_idle_on) begin
            out_stall <= ($urandom_range(99) < 10);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Result checker: each transfer against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_counts.size() == 0) begin
                $error("result transfer with no evaluation pending: sign_changes %0d on_root %0d",
                       sign_changes, on_root);
                mismatches++;
            end else begin
                want = pending_counts.pop_front();
                if (sign_changes !== want.sign_changes) begin
                    $error("sign_changes: expected %0d, actual %0d",
                           want.sign_changes, sign_changes);
                    mismatches++;
                end
                if (on_root !== want.on_root) begin
                    $error("on_root: expected %0d, actual %0d", want.on_root, on_root);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Store comes out of reset cleared: every polynomial is zero, so the
    // first one reads as a root and there are no signs to count.
    task automatic test_cleared_store();
        cfg_write(5'd31);                  // above the limit, acts as all 16
        eval_at('0);
        eval_at(32'h7FFF_FFFF);
        wait_drained();
    endtask

    // Extreme coefficients and points at the corners of both index ranges.
    task automatic test_coeff_extremes();
        cfg_write(5'd16);
        write_coeff(MAX_POLYS - 1, MAX_COEFFS - 1, 32'h7FFF_FFFF);
        write_coeff(0, MAX_COEFFS - 1, 32'h8000_0000);
        write_coeff(5, 0, 32'h7FFF_FFFF);
        eval_at(32'h7FFF_FFFF);
        eval_at(32'h8000_0000);
        eval_at(Q_ONE);
        eval_at('0);
        write_coeff(MAX_POLYS - 1, MAX_COEFFS - 1, '0);
        write_coeff(0, MAX_COEFFS - 1, '0);
        write_coeff(5, 0, '0);
        wait_drained();
    endtask

    // Hand-built sequence x^2 - 1, 2x, 1: two changes left of both roots,
    // none right of them, a zero middle value at x = 0, a root at x = 1.
    // Then the low clamp of the active count and a value just over 16.
    task automatic test_known_sequence();
        cfg_write(5'd3);
        write_coeff(0, 2, Q_ONE);
        write_coeff(0, 0, -Q_ONE);
        write_coeff(1, 1, 32'h0002_0000);
        write_coeff(2, 0, Q_ONE);
        eval_at(-32'sh0002_0000);
        eval_at('0);
        eval_at(Q_ONE);
        eval_at(32'h0002_0000);
        wait_drained();
        cfg_write(5'd0);                   // acts as one polynomial
        eval_at(Q_ONE);
        wait_drained();
        cfg_write(5'd17);                  // acts as all 16
        eval_at(-32'sh0002_0000);
        wait_drained();
    endtask

    // One well-formed phase: pick an active count, load a sequence of
    // falling degree, sprinkle a few stray writes, evaluate at several points.
    task automatic run_sequence_phase();
        logic [ACTIVE_W-1:0] cfg;
        int                  npoly, top_deg, deg, root_at;
        bit                  root_form;
        logic [COEFF_W-1:0]  val;
        case ($urandom_range(9))
            0:       cfg = $urandom_range(1) ? 5'd0 : 5'($urandom_range(17, 31));
            1, 2:    cfg = 5'($urandom_range(5, 16));
            default: cfg = 5'($urandom_range(1, 4));
        endcase
        npoly     = (cfg == 0) ? 1 : (cfg > MAX_POLYS) ? MAX_POLYS : int'(cfg);
        top_deg   = $urandom_range(6);
        root_form = ($urandom_range(3) == 0);
        root_at   = int'($urandom_range(8)) - 4;
        wait_drained();
        cfg_write(cfg);
        for (int p = 0; p < npoly; p++) begin
            deg = (top_deg > p) ? top_deg - p : 0;
            if ($urandom_range(9) == 0)
                deg = $urandom_range(MAX_COEFFS - 1);
            for (int k = 0; k < MAX_COEFFS; k++) begin
                if (p == 0 && root_form)
                    val = (k == 1) ? Q_ONE : (k == 0) ? -(root_at <<< 16) : '0;
                else
                    val = (k <= deg) ? rand_coeff() : '0;
                // skip zeros the store already holds
                if (val != 0 || coeff_model[p][k] != 0)
                    write_coeff(p, k, val);
            end
        end
        // stray writes anywhere: break the sequence now and then
        repeat ($urandom_range(2))
            write_coeff($urandom_range(MAX_POLYS - 1), $urandom_range(MAX_COEFFS - 1), $urandom);
        repeat ($urandom_range(3, 8)) begin
            if (root_form && $urandom_range(2) == 0)
                eval_at(root_at <<< 16);
            else
                eval_at(rand_x());
        end
    endtask

    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        while (items_sent < B2B_ITEMS)
            run_sequence_phase();
        wait_drained();
    endtask

    // Receiver holds off while evaluations keep coming: the output register
    // fills, the next result waits inside, and the input channel stalls.
    task automatic test_output_backpressure();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        wait_drained();
        cfg_write(5'd2);
        rx_hold_left = 2000;
        repeat (8)
            eval_at(rand_x());
        wait_drained();
    endtask

    task automatic test_random_sequences();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        while (items_sent < ITEM_TARGET)
            run_sequence_phase();
        wait_drained();
    endtask

    initial begin
        // synchronous reset, released at a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_cleared_store();
        test_coeff_extremes();
        test_known_sequence();
        test_back_to_back();
        test_output_backpressure();
        test_random_sequences();

        // let any stray late result show up before the verdict
        repeat (EVAL_CYCLES + 100) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/ssvc_pkg.sv
rtl/ssvc_dp.sv
rtl/ssvc_ctrl.sv
rtl/sturm_sign_variation_count_core.sv
tb/tb_top.sv
